/* hw/rtl/spbar_pkg.sv */
// ----------------------------------------------------------------------------
// spbar_pkg: shared constants and helpers for the spectrum bar meter
// Field widths, level offsets, decay steps and the divide-by-three helper.
// ----------------------------------------------------------------------------
package spbar_pkg;

  localparam int NUM_BARS_DEF = 16;

  localparam int IDX_W   = 4;
  localparam int LEVEL_W = 8;
  localparam int MODE_W  = 2;
  localparam int DATA_W  = 24;

  typedef logic [IDX_W-1:0]   bar_idx_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [MODE_W-1:0]  mode_t;

  localparam mode_t MODE_AVG    = 2'd0;
  localparam mode_t MODE_ILV_40 = 2'd1;
  localparam mode_t MODE_ILV_60 = 2'd2;

  localparam logic signed [9:0] OFFSET_LO  = 10'sd40;
  localparam logic signed [9:0] OFFSET_HI  = 10'sd60;
  localparam level_t            BAR_DECAY  = 8'd4;
  localparam logic signed [9:0] PEAK_DECAY = 10'sd2;
  localparam logic [9:0]        PEAK_GAP   = 10'd2;
  localparam logic [15:0]       RECIP3     = 16'd171;

  // round an 8-bit value down to a multiple of three
  function automatic level_t quant3(input level_t v);
    logic [15:0] prod;
    logic [6:0]  quo;
    logic [8:0]  back;
    prod = {8'd0, v} * RECIP3;
    quo  = prod[15:9];
    back = {1'b0, quo, 1'b0} + {2'b00, quo};
    return back[7:0];
  endfunction

endpackage

/* hw/rtl/spectrum_bar_peak_hold_top.sv */
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_top: bar graph meter with decay and peak hold
//
//   port group    dir  beat contents
//   s_*           in   bar index, short and long level, source valid flag
//   m_*           out  bar index, new bar height, new peak height
//   cfg_*         in   source mode register write
//
// One beat per cycle in and out unless stalled; beats pass the input and
// output stages. Bar and peak stores are read and written in the same
// stage, so beats for the same bar may follow back to back. rst clears the
// stores, the source mode and both pipeline stages. A stalled output holds
// the input stage, which still takes a beat while its own slot is free.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_hold_top
  import spbar_pkg::*;
#(
  parameter int NUM_BARS = NUM_BARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // bar_index[3:0], short_level[11:4], long_level[19:12]
  input  logic              s_tuser,   // source_valid
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // out_bar_index[3:0], bar_height[11:4], peak_height[19:12]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_data   // source_mode
);

  localparam int DEPTH = (NUM_BARS < (1 << IDX_W)) ? NUM_BARS : (1 << IDX_W);
  localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mode_t    mode;
  level_t   bar_store  [DEPTH];
  level_t   peak_store [DEPTH];

  logic     in_vld;
  bar_idx_t in_idx;
  level_t   in_short;
  level_t   in_long;
  logic     in_src;

  logic     out_vld;
  bar_idx_t out_idx;
  level_t   out_bar;
  level_t   out_peak;

  logic     advance;
  logic     in_range;
  logic [SEL_W-1:0] sel;
  level_t   bar_rd;
  level_t   peak_rd;
  logic [8:0] sum;
  level_t   pick;
  logic signed [9:0] level;
  level_t   bar_dec;
  level_t   bar_raised;
  level_t   bar_next;
  logic signed [9:0] peak_dec;
  logic signed [9:0] peak_floor;
  logic signed [9:0] peak_sel;
  level_t   peak_next;

  assign cfg_ready = 1'b1;
  assign advance   = !out_vld || m_tready;
  assign s_tready  = !in_vld || advance;
  assign m_tvalid  = out_vld;
  assign m_tdata   = {4'd0, out_peak, out_bar, out_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_AVG;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_idx   <= s_tdata[3:0];
      in_short <= s_tdata[11:4];
      in_long  <= s_tdata[19:12];
      in_src   <= s_tuser;
    end
  end

  assign in_range = ({1'b0, in_idx} < (IDX_W + 1)'(DEPTH));
  assign sel      = in_range ? in_idx[SEL_W-1:0] : '0;
  assign bar_rd   = bar_store[sel];
  assign peak_rd  = peak_store[sel];

  always_comb begin
    sum  = {1'b0, in_short} + {1'b0, in_long};
    pick = in_idx[0] ? in_long : in_short;
    if (!in_src) begin
      level = '0;
    end else begin
      case (mode)
        MODE_AVG:    level = $signed({2'b00, sum[8:1]}) - OFFSET_LO;
        MODE_ILV_40: level = $signed({2'b00, pick}) - OFFSET_LO;
        MODE_ILV_60: level = $signed({2'b00, pick}) - OFFSET_HI;
        default:     level = '0;
      endcase
    end

    bar_dec    = (bar_rd >= BAR_DECAY) ? (bar_rd - BAR_DECAY) : '0;
    bar_raised = (level > $signed({2'b00, bar_dec})) ? level[7:0] : bar_dec;
    bar_next   = quant3(bar_raised);

    peak_dec   = $signed({2'b00, peak_rd}) - PEAK_DECAY;
    peak_floor = $signed({2'b00, bar_next} + PEAK_GAP);
    if (bar_next == '0) begin
      peak_sel = (peak_dec < 0) ? '0 : peak_dec;
    end else begin
      peak_sel = (peak_dec < peak_floor) ? peak_floor : peak_dec;
    end
    peak_next = (peak_sel > 10'sd255) ? 8'd255 : peak_sel[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        bar_store[i]  <= '0;
        peak_store[i] <= '0;
      end
    end else if (advance && in_vld && in_range) begin
      bar_store[sel]  <= bar_next;
      peak_store[sel] <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld) begin
      out_idx  <= in_idx;
      out_bar  <= in_range ? bar_next : '0;
      out_peak <= in_range ? peak_next : '0;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_bar_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[11:4] != 8'd0) |-> (m_tdata[11:4] == quant3(m_tdata[11:4])))
    else $error("bar height not a multiple of three");

  a_peak_above: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[11:4] != 8'd0) |->
      ({1'b0, m_tdata[19:12]} >= {1'b0, m_tdata[11:4]} + 9'd2))
    else $error("peak below bar plus gap");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && {1'b0, m_tdata[3:0]} >= (IDX_W + 1)'(DEPTH)) |->
      (m_tdata[19:4] == 16'd0))
    else $error("unmapped bar with nonzero heights");

  a_store_hold: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !advance) |=> (in_vld && $stable(bar_rd) && $stable(peak_rd)))
    else $error("store changed under a stalled beat");

endmodule
